>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared codes for the software timer table: command actions, timer modes
// and result status values.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 8;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [1:0] MODE_SINGLE   = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_BADMODE  = 3'd3;
  localparam logic [2:0] ST_ZEROPER  = 3'd4;

endpackage

>>> rtl/software_timer_table_top.sv
// ----------------------------------------------------------------------------
// software_timer_table_top
// Table of software timers with start, stop, tick and clear commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Start and clear
// finish in the cycle they are taken: busy stays low and the single result
// shows on the next cycle, so these commands can be issued back to back.
// Stop and tick walk the timer table through one read port and one shared
// counter/compare unit, reading each entry and then examining it, with busy
// high meanwhile. A single-shot expiry pulls the last entry into the freed
// slot and examines it in the next cycle. Results appear one per cycle at
// most, each for exactly one cycle with out_valid high; there is no back
// pressure, so the receiver must take every transfer as it comes. A tick
// on which no counter reaches its period gives no transfer at all;
// otherwise out_last marks the final transfer of the command.
// ----------------------------------------------------------------------------
module software_timer_table_top #(
  parameter int unsigned TABLE_DEPTH = stt_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_action,
  input  logic [7:0] in_task_id,
  input  logic [7:0] in_period,
  input  logic [1:0] in_mode,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic       out_fired,
  output logic [7:0] out_fired_id,
  output logic [3:0] out_active_count,
  output logic       out_last
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] period;
    logic [1:0] mode;
    logic [7:0] counter;
  } entry_t;

  typedef struct packed {
    logic [2:0] status;
    logic       fired;
    logic [7:0] id;
  } res_t;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EX, S_MV} state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_v_r, pend_v_nxt;
  res_t             pend_r, pend_nxt;
  logic [CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic             ov_r, ov_nxt;
  res_t             ores_r, ores_nxt;
  logic [CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic             olast_r, olast_nxt;

  entry_t           mem [TABLE_DEPTH];
  entry_t           mem_q_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  logic [IDX_W-1:0] mem_ra;

  entry_t           e;
  logic [7:0]       nc;
  logic             hit;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] idx_inc;
  logic             new_v;
  res_t             new_res;
  logic [CNT_W-1:0] new_cnt;
  logic [CNT_W+3:0] ocnt_ext;

  assign e       = mem_q_r;
  assign nc      = e.counter + 8'd1;
  assign hit     = (nc == e.period);
  assign cnt_dec = cnt_r - ONE_C;
  assign idx_inc = idx_r + ONE_C;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    pend_cnt_nxt = pend_cnt_r;
    ov_nxt       = 1'b0;
    ores_nxt     = ores_r;
    ocnt_nxt     = ocnt_r;
    olast_nxt    = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = idx_r[IDX_W-1:0];
    mem_wd       = e;
    mem_ra       = idx_r[IDX_W-1:0];
    new_v        = 1'b0;
    new_res      = '0;
    new_cnt      = cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_action)
            stt_pkg::ACT_START: begin
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
              ores_nxt  = '{status: stt_pkg::ST_OK, fired: 1'b0, id: 8'd0};
              ocnt_nxt  = cnt_r;
              if (cnt_r >= DEPTH_C) begin
                ores_nxt.status = stt_pkg::ST_FULL;
              end else if (in_period == 8'd0) begin
                ores_nxt.status = stt_pkg::ST_ZEROPER;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = cnt_r[IDX_W-1:0];
                mem_wd   = '{id: in_task_id, period: in_period, mode: in_mode,
                             counter: 8'd0};
                cnt_nxt  = cnt_r + ONE_C;
                ocnt_nxt = cnt_r + ONE_C;
              end
            end
            stt_pkg::ACT_CLEAR: begin
              cnt_nxt   = '0;
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
              ores_nxt  = '{status: stt_pkg::ST_OK, fired: 1'b0, id: 8'd0};
              ocnt_nxt  = '0;
            end
            default: begin
              // stop or tick: walk the table
              op_nxt     = in_action;
              id_nxt     = in_task_id;
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_RD;
            end
          endcase
        end
      end

      S_RD: begin
        if (idx_r >= cnt_r) begin
          state_nxt = S_IDLE;
          if (op_r == stt_pkg::ACT_STOP) begin
            ov_nxt    = 1'b1;
            olast_nxt = 1'b1;
            ores_nxt  = '{status: stt_pkg::ST_NOTFOUND, fired: 1'b0, id: 8'd0};
            ocnt_nxt  = cnt_r;
          end else if (pend_v_r) begin
            ov_nxt     = 1'b1;
            olast_nxt  = 1'b1;
            ores_nxt   = pend_r;
            ocnt_nxt   = pend_cnt_r;
            pend_v_nxt = 1'b0;
          end
        end else begin
          state_nxt = S_EX;
        end
      end

      S_EX: begin
        if (op_r == stt_pkg::ACT_STOP) begin
          if (e.id == id_r) begin
            cnt_nxt   = cnt_dec;
            ov_nxt    = 1'b1;
            olast_nxt = 1'b1;
            ores_nxt  = '{status: stt_pkg::ST_OK, fired: 1'b0, id: 8'd0};
            ocnt_nxt  = cnt_dec;
            if (idx_r < cnt_dec) begin
              mem_ra    = cnt_dec[IDX_W-1:0];
              state_nxt = S_MV;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_RD;
          end
        end else if (hit && (e.mode == stt_pkg::MODE_SINGLE)) begin
          // drop this slot; the last entry moves in and is examined next
          cnt_nxt = cnt_dec;
          new_v   = 1'b1;
          new_res = '{status: stt_pkg::ST_OK, fired: 1'b1, id: e.id};
          new_cnt = cnt_dec;
          if (idx_r < cnt_dec) begin
            mem_ra    = cnt_dec[IDX_W-1:0];
            state_nxt = S_EX;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          mem_we         = 1'b1;
          mem_wd.counter = (hit && (e.mode == stt_pkg::MODE_PERIODIC)) ? 8'd0 : nc;
          idx_nxt        = idx_inc;
          state_nxt      = S_RD;
          if (hit) begin
            new_v = 1'b1;
            if (e.mode == stt_pkg::MODE_PERIODIC) begin
              new_res = '{status: stt_pkg::ST_OK, fired: 1'b1, id: e.id};
            end else begin
              new_res = '{status: stt_pkg::ST_BADMODE, fired: 1'b0, id: 8'd0};
            end
          end
        end
      end

      S_MV: begin
        mem_we    = 1'b1;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // tick results are held back one step so the final one can carry last
    if (new_v) begin
      if (pend_v_r) begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b0;
        ores_nxt  = pend_r;
        ocnt_nxt  = pend_cnt_r;
      end
      pend_v_nxt   = 1'b1;
      pend_nxt     = new_res;
      pend_cnt_nxt = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    idx_r      <= idx_nxt;
    pend_r     <= pend_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    ores_r     <= ores_nxt;
    ocnt_r     <= ocnt_nxt;
    olast_r    <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  assign ocnt_ext = {4'b0000, ocnt_r};

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_status       = ores_r.status;
  assign out_fired        = ores_r.fired;
  assign out_fired_id     = ores_r.id;
  assign out_active_count = ocnt_ext[3:0];
  assign out_last         = olast_r;

endmodule

>>> rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks for the software timer table, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic       out_fired,
  input logic [7:0] out_fired_id,
  input logic [3:0] out_active_count,
  input logic       out_last
);

  // start and clear complete at once with a single, final transfer
  a_quick_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == stt_pkg::ACT_START ||
                       in_action == stt_pkg::ACT_CLEAR)
    |=> out_valid && out_last && !busy)
    else $error("start/clear did not give one final transfer");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == stt_pkg::ACT_CLEAR
    |=> out_active_count == 4'd0)
    else $error("clear left active timers");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_status == stt_pkg::ST_OK)
    else $error("fired transfer with error status");

  a_nofire_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_fired_id == 8'd0)
    else $error("fired_id set without fired");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= stt_pkg::ST_ZEROPER)
    else $error("status code out of range");

endmodule

bind software_timer_table_top stt_checker u_stt_checker (.*);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for software_timer_table_top. Commands go in over the
// start/busy handshake in bursts with random gaps between them. An in-bench
// timer table predicts every result transfer, and each transfer on the
// strobed output port is compared field by field against the oldest
// prediction. The stimulus is a directed pass over the corner cases, then a
// run of ticks over a mixed table, then random traffic.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = stt_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned RANDOM_ITEMS = 60;
  localparam int unsigned WRAP_TICKS   = 60;
  // modes with no meaning to the block; they linger and report errors
  localparam logic [1:0] MODE_BAD_A = 2'd2;
  localparam logic [1:0] MODE_BAD_B = 2'd3;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] period;
    logic [1:0] mode;
    logic [7:0] ticks;
  } timer_slot_t;

  typedef struct packed {
    logic [2:0] status;
    logic       fired;
    logic [7:0] fired_id;
    logic [3:0] active;
    logic       last;
  } timer_result_t;

  class timer_scoreboard;
    timer_slot_t   slots[DEPTH];
    int unsigned   n_active;
    timer_result_t expected_q[$];
    int unsigned   errors;

    function new();
      n_active = 0;
      errors   = 0;
    endfunction

    function void post(logic [2:0] status, logic fired, logic [7:0] fired_id);
      timer_result_t r;
      r.status   = status;
      r.fired    = fired;
      r.fired_id = fired_id;
      r.active   = n_active[3:0];
      r.last     = 1'b0;
      expected_q.push_back(r);
    endfunction

    // freed slot takes the last entry
    function void drop(int unsigned idx);
      slots[idx] = slots[n_active - 1];
      n_active--;
    endfunction

    // predicts the results of one accepted command
    function void note_command(logic [1:0] action, logic [7:0] id,
                               logic [7:0] period, logic [1:0] mode);
      int unsigned   first;
      int unsigned   i;
      logic [2:0]    status;
      logic [7:0]    fid;
      timer_result_t r;
      first = expected_q.size();
      case (action)
        stt_pkg::ACT_START: begin
          if (n_active >= DEPTH) begin
            post(stt_pkg::ST_FULL, 1'b0, 8'd0);
          end else if (period == 8'd0) begin
            post(stt_pkg::ST_ZEROPER, 1'b0, 8'd0);
          end else begin
            slots[n_active] = '{id, period, mode, 8'd0};
            n_active++;
            post(stt_pkg::ST_OK, 1'b0, 8'd0);
          end
        end
        stt_pkg::ACT_STOP: begin
          status = stt_pkg::ST_NOTFOUND;
          for (i = 0; i < n_active; i++) begin
            if (slots[i].id == id) begin
              drop(i);
              status = stt_pkg::ST_OK;
              break;
            end
          end
          post(status, 1'b0, 8'd0);
        end
        stt_pkg::ACT_CLEAR: begin
          n_active = 0;
          post(stt_pkg::ST_OK, 1'b0, 8'd0);
        end
        default: begin
          i = 0;
          while (i < n_active) begin
            slots[i].ticks = slots[i].ticks + 8'd1;
            if (slots[i].ticks != slots[i].period) begin
              i++;
            end else if (slots[i].mode == stt_pkg::MODE_SINGLE) begin
              // moved-in entry is examined on the next pass, same index
              fid = slots[i].id;
              drop(i);
              post(stt_pkg::ST_OK, 1'b1, fid);
            end else if (slots[i].mode == stt_pkg::MODE_PERIODIC) begin
              slots[i].ticks = 8'd0;
              post(stt_pkg::ST_OK, 1'b1, slots[i].id);
              i++;
            end else begin
              post(stt_pkg::ST_BADMODE, 1'b0, 8'd0);
              i++;
            end
          end
        end
      endcase
      if (expected_q.size() > first) begin
        r = expected_q[expected_q.size() - 1];
        r.last = 1'b1;
        expected_q[expected_q.size() - 1] = r;
      end
    endfunction

    function void compare(string field, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v,
                 got_v);
        errors++;
      end
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %h", $time,
                 got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        compare("status", 32'(exp_r.status), 32'(got.status));
        compare("fired", 32'(exp_r.fired), 32'(got.fired));
        compare("fired_id", 32'(exp_r.fired_id), 32'(got.fired_id));
        compare("active_count", 32'(exp_r.active), 32'(got.active));
        compare("last", 32'(exp_r.last), 32'(got.last));
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       start      = 1'b0;
  logic [1:0] in_action  = '0;
  logic [7:0] in_task_id = '0;
  logic [7:0] in_period  = '0;
  logic [1:0] in_mode    = '0;
  logic       busy;
  logic       out_valid;
  logic [2:0] out_status;
  logic       out_fired;
  logic [7:0] out_fired_id;
  logic [3:0] out_active_count;
  logic       out_last;

  timer_scoreboard sb;
  int unsigned     cycle_count = 0;

  software_timer_table_top #(.TABLE_DEPTH(DEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_task_id       (in_task_id),
    .in_period        (in_period),
    .in_mode          (in_mode),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_fired        (out_fired),
    .out_fired_id     (out_fired_id),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("** software_timer_table_top: FAILED **");
      $finish;
    end
  end

  // result transfers are checked before the command taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_result(timer_result_t'{out_status, out_fired, out_fired_id,
                                        out_active_count, out_last});
      end
      if (start && !busy) begin
        sb.note_command(in_action, in_task_id, in_period, in_mode);
      end
    end
  end

  // holds the command until the transfer edge; start stays high afterwards
  task automatic send(logic [1:0] action, logic [7:0] id, logic [7:0] period,
                      logic [1:0] mode);
    start      <= 1'b1;
    in_action  <= action;
    in_task_id <= id;
    in_period  <= period;
    in_mode    <= mode;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
  endfunction

  task automatic send_random();
    logic [1:0]  action;
    logic [7:0]  id;
    logic [7:0]  period;
    logic [1:0]  mode;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) action = stt_pkg::ACT_START;
    else if (pick < 60) action = stt_pkg::ACT_STOP;
    else if (pick < 94) action = stt_pkg::ACT_TICK;
    else action = stt_pkg::ACT_CLEAR;

    pick = $urandom_range(0, 9);
    if (action == stt_pkg::ACT_STOP && sb.n_active > 0 && pick < 7) begin
      id = sb.slots[$urandom_range(0, sb.n_active - 1)].id;
    end else if (pick < 5) begin
      id = 8'($urandom_range(0, 7));
    end else begin
      id = 8'($urandom_range(0, 255));
    end

    pick = $urandom_range(0, 19);
    if (action != stt_pkg::ACT_START || pick == 19) period = 8'($urandom_range(0, 255));
    else if (pick < 12) period = 8'($urandom_range(1, 4));
    else if (pick < 16) period = 8'($urandom_range(5, 40));
    else if (pick < 18) period = 8'd0;
    else period = 8'd255;

    if (action != stt_pkg::ACT_START || $urandom_range(0, 99) < 15) begin
      mode = 2'($urandom_range(0, 3));
    end else begin
      mode = $urandom_range(0, 1) ? stt_pkg::MODE_PERIODIC : stt_pkg::MODE_SINGLE;
    end

    send(action, id, period, mode);
  endtask

  initial begin
    int unsigned issued;
    int unsigned burst;
    int unsigned k;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases
    send(stt_pkg::ACT_STOP, 8'h00, 8'h00, stt_pkg::MODE_SINGLE);   // stop on empty table
    send(stt_pkg::ACT_TICK, 8'hFF, 8'hFF, MODE_BAD_B);             // tick on empty table
    send(stt_pkg::ACT_START, 8'hFF, 8'h00, stt_pkg::MODE_SINGLE);  // zero period
    send(stt_pkg::ACT_START, 8'h00, 8'd1, stt_pkg::MODE_SINGLE);
    send(stt_pkg::ACT_START, 8'hAA, 8'd2, stt_pkg::MODE_PERIODIC);
    pause(2);
    send(stt_pkg::ACT_START, 8'h55, 8'd1, MODE_BAD_A);
    send(stt_pkg::ACT_START, 8'h0F, 8'd255, MODE_BAD_B);
    send(stt_pkg::ACT_START, 8'hF0, 8'd3, stt_pkg::MODE_SINGLE);
    send(stt_pkg::ACT_START, 8'h01, 8'd1, stt_pkg::MODE_PERIODIC);
    send(stt_pkg::ACT_START, 8'h02, 8'd128, stt_pkg::MODE_SINGLE);
    send(stt_pkg::ACT_START, 8'h03, 8'd1, stt_pkg::MODE_SINGLE);   // table now full
    send(stt_pkg::ACT_START, 8'h04, 8'd5, stt_pkg::MODE_PERIODIC); // full
    send(stt_pkg::ACT_START, 8'h04, 8'd0, stt_pkg::MODE_SINGLE);   // full beats zero period
    send(stt_pkg::ACT_TICK, 8'h00, 8'h00, stt_pkg::MODE_SINGLE);   // removals, moves
    pause(1);
    send(stt_pkg::ACT_TICK, 8'h00, 8'h00, stt_pkg::MODE_SINGLE);
    send(stt_pkg::ACT_STOP, 8'hAA, 8'h00, stt_pkg::MODE_SINGLE);
    send(stt_pkg::ACT_STOP, 8'h77, 8'h00, stt_pkg::MODE_SINGLE);   // absent id
    send(stt_pkg::ACT_START, 8'h01, 8'd2, stt_pkg::MODE_SINGLE);   // duplicate id
    send(stt_pkg::ACT_STOP, 8'h01, 8'h00, stt_pkg::MODE_SINGLE);   // first match only
    send(stt_pkg::ACT_TICK, 8'h00, 8'h00, stt_pkg::MODE_SINGLE);
    send(stt_pkg::ACT_TICK, 8'h00, 8'h00, stt_pkg::MODE_SINGLE);
    send(stt_pkg::ACT_CLEAR, 8'hFF, 8'hFF, MODE_BAD_B);
    send(stt_pkg::ACT_STOP, 8'h00, 8'h00, stt_pkg::MODE_SINGLE);
    send(stt_pkg::ACT_TICK, 8'h00, 8'h00, stt_pkg::MODE_SINGLE);
    pause(3);

    // tick run: periodic restarts, a late single shot and a bad-mode entry
    send(stt_pkg::ACT_START, 8'hC3, 8'd40, stt_pkg::MODE_SINGLE);
    send(stt_pkg::ACT_START, 8'h3C, 8'd7, stt_pkg::MODE_PERIODIC);
    send(stt_pkg::ACT_START, 8'h99, 8'd2, MODE_BAD_B);
    send(stt_pkg::ACT_START, 8'h66, 8'd20, stt_pkg::MODE_PERIODIC);
    issued = 0;
    while (issued < WRAP_TICKS) begin
      burst = $urandom_range(1, 40);
      for (k = 0; k < burst && issued < WRAP_TICKS; k++) begin
        send(stt_pkg::ACT_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             2'($urandom_range(0, 3)));
        issued++;
      end
      pause(gap_len());
    end
    send(stt_pkg::ACT_CLEAR, 8'h00, 8'h00, stt_pkg::MODE_SINGLE);
    pause(2);

    // random traffic
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 6);
      for (k = 0; k < burst && issued < RANDOM_ITEMS; k++) begin
        send_random();
        issued++;
      end
      pause(gap_len());
    end
    pause(1);

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("** software_timer_table_top: PASSED **");
    end else begin
      $display("** software_timer_table_top: FAILED **");
    end
    $finish;
  end

endmodule
